>>> design/ibl_pkg.sv
// ----------------------------------------------------------------------------
// ibl_pkg: shared types and constants of the input binding learner
// Mode and kind codes, config register indexes, controller state type and
// the command/status groups between the controller and the datapath.
// ----------------------------------------------------------------------------
package ibl_pkg;

	localparam int SLOTS_DEFAULT = 64;
	localparam int KEY_W         = 13;
	localparam int DIV_STEPS     = 64;
	localparam int DIV_CNT_W     = $clog2(DIV_STEPS);

	localparam logic [1:0] MODE_IDLE  = 2'd0;
	localparam logic [1:0] MODE_LEARN = 2'd1;
	localparam logic [1:0] MODE_RUN   = 2'd2;

	localparam logic [1:0] KIND_KEY  = 2'd1;
	localparam logic [1:0] KIND_AXIS = 2'd2;

	localparam logic REG_PRESS_THRESHOLD = 1'b0;
	localparam logic REG_ARM_REPEAT      = 1'b1;

	localparam logic [31:0] THRESHOLD_RESET = 32'h7FFF_FFFF;
	localparam logic [7:0]  ARM_RESET       = 8'd10;
	localparam logic [6:0]  PRESS_CNT_MAX   = 7'd127;
	localparam logic [6:0]  ARM_MIN         = 7'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV_GO,
		ST_DIV_WAIT,
		ST_SRCH_RD,
		ST_SRCH_CMP,
		ST_COMMIT
	} ctrl_state_t;

	typedef struct packed {
		logic capture;
		logic div_start;
		logic srch_rd;
		logic srch_cmp;
		logic commit;
	} cmd_t;

	typedef struct packed {
		logic is_axis;
		logic div_done;
		logic srch_active;
		logic srch_more;
		logic found;
		logic out_free;
	} status_t;

endpackage

>>> design/input_binding_learner.sv
// ----------------------------------------------------------------------------
// input_binding_learner: learns input bindings and reports bound inputs
// Scales each key or axis event, arms learning on a repeated press, binds
// new presses to slots and reports slot and magnitude in run mode.
//
// Channel  | Direction | Handshake           | Payload
// ---------+-----------+---------------------+---------------------------------
// in       | into      | in_valid/in_stall   | event_kind, event_code,
//          |           |                     | raw_value, axis_min, axis_max
// out      | out of    | out_valid/out_stall | mode, binding_added, slot_hit,
//          |           |                     | slot_index, slot_value
// cfg      | into      | cfg_we              | cfg_index, cfg_data
//
// Sequence, one word at a time: accept, a setup state, the bit-serial
// divider for axis words only, a read and a compare per table entry
// searched (up to SLOTS), a last check that ends the search, and a commit.
// Reset clears mode, counters and trigger and sets config to its defaults;
// the table is not cleared. A stalled result holds in the output register
// while the next word is taken and waits in commit until the register frees.
// ----------------------------------------------------------------------------
module input_binding_learner #(
	parameter int SLOTS = ibl_pkg::SLOTS_DEFAULT
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic [31:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         event_kind,
	input  logic [9:0]         event_code,
	input  logic signed [31:0] raw_value,
	input  logic signed [31:0] axis_min,
	input  logic [30:0]        axis_max,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [1:0]         mode,
	output logic               binding_added,
	output logic               slot_hit,
	output logic [5:0]         slot_index,
	output logic [31:0]        slot_value
);
	import ibl_pkg::*;

	cmd_t    cmd;
	status_t status;

	// sequence each word through the datapath
	ibl_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.status  (status),
		.cmd     (cmd)
	);

	// hold config, scale, search the table, register the result
	ibl_dp #(
		.SLOTS(SLOTS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.event_kind   (event_kind),
		.event_code   (event_code),
		.raw_value    (raw_value),
		.axis_min     (axis_min),
		.axis_max     (axis_max),
		.cmd          (cmd),
		.status       (status),
		.out_stall    (out_stall),
		.out_valid    (out_valid),
		.mode         (mode),
		.binding_added(binding_added),
		.slot_hit     (slot_hit),
		.slot_index   (slot_index),
		.slot_value   (slot_value)
	);

endmodule

>>> design/ibl_div.sv
// ----------------------------------------------------------------------------
// ibl_div: iterative scaler divider
// Computes (num * (2^32 - 1)) / den one quotient bit per cycle, restoring.
// ----------------------------------------------------------------------------
module ibl_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] num,
	input  logic [31:0] den,
	output logic        done,
	output logic [31:0] quot
);
	import ibl_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] step_q;
	logic [31:0]          rem_q;
	logic [63:0]          dq_q;
	logic [63:0]          dividend;
	logic [32:0]          trial;
	logic                 qbit;

	// num * (2^32 - 1) as a shift and a subtract
	assign dividend = {num, 32'd0} - {32'd0, num};
	assign trial    = {rem_q, dq_q[63]};
	assign qbit     = (trial >= {1'b0, den});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= DIV_CNT_W'(DIV_STEPS - 1);
			end else if (busy_q) begin
				step_q <= step_q - 1'b1;
				if (step_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dq_q  <= dividend;
		end else if (busy_q) begin
			rem_q <= qbit ? 32'(trial - {1'b0, den}) : trial[31:0];
			dq_q  <= {dq_q[62:0], qbit};
		end
	end

	assign done = done_q;
	assign quot = dq_q[31:0];

endmodule

>>> design/ibl_ctrl.sv
// ----------------------------------------------------------------------------
// ibl_ctrl: sequencing controller
// Steps one word through capture, scaling, table search and commit.
// ----------------------------------------------------------------------------
module ibl_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  ibl_pkg::status_t status,
	output ibl_pkg::cmd_t    cmd
);
	import ibl_pkg::*;

	ctrl_state_t state_q;
	ctrl_state_t state_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	always_comb begin
		state_n = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) state_n = ST_DIV_GO;
			end
			ST_DIV_GO: begin
				state_n = status.is_axis ? ST_DIV_WAIT : ST_SRCH_RD;
			end
			ST_DIV_WAIT: begin
				if (status.div_done) state_n = ST_SRCH_RD;
			end
			ST_SRCH_RD: begin
				if (!status.srch_active || status.found || !status.srch_more)
					state_n = ST_COMMIT;
				else
					state_n = ST_SRCH_CMP;
			end
			ST_SRCH_CMP: begin
				state_n = ST_SRCH_RD;
			end
			ST_COMMIT: begin
				if (status.out_free) state_n = ST_IDLE;
			end
			default: state_n = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_stall = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				in_stall    = 1'b0;
				cmd.capture = in_valid;
			end
			ST_DIV_GO: begin
				cmd.div_start = status.is_axis;
			end
			ST_DIV_WAIT: begin
			end
			ST_SRCH_RD: begin
				cmd.srch_rd = status.srch_active && !status.found && status.srch_more;
			end
			ST_SRCH_CMP: begin
				cmd.srch_cmp = 1'b1;
			end
			ST_COMMIT: begin
				cmd.commit = status.out_free;
			end
			default: begin
			end
		endcase
	end

endmodule

>>> design/ibl_dp.sv
// ----------------------------------------------------------------------------
// ibl_dp: learner datapath
// Config registers, word capture, scaling, binding table and result register.
// ----------------------------------------------------------------------------
module ibl_dp #(
	parameter int SLOTS = ibl_pkg::SLOTS_DEFAULT
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic [31:0]        cfg_data,
	input  logic [1:0]         event_kind,
	input  logic [9:0]         event_code,
	input  logic signed [31:0] raw_value,
	input  logic signed [31:0] axis_min,
	input  logic [30:0]        axis_max,
	input  ibl_pkg::cmd_t      cmd,
	output ibl_pkg::status_t   status,
	input  logic               out_stall,
	output logic               out_valid,
	output logic [1:0]         mode,
	output logic               binding_added,
	output logic               slot_hit,
	output logic [5:0]         slot_index,
	output logic [31:0]        slot_value
);
	import ibl_pkg::*;

	localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CW = ($clog2(SLOTS + 1) > 7) ? $clog2(SLOTS + 1) : 7;

	logic [31:0]      thr_q;
	logic [7:0]       arm_q;
	logic [1:0]       kind_q;
	logic [9:0]       code_q;
	logic [31:0]      raw_q;
	logic [31:0]      amin_q;
	logic [30:0]      amax_q;
	logic [1:0]       mode_q;
	logic [CW-1:0]    cnt_q;
	logic [KEY_W-1:0] trig_q;
	logic [KEY_W-1:0] table_mem [SLOTS];
	logic [KEY_W-1:0] rdata_q;
	logic [CW-1:0]    idx_q;
	logic             found_q;
	logic [AW-1:0]    found_idx_q;
	logic             out_valid_q;
	logic [1:0]       mode_out_q;
	logic             added_out_q;
	logic             hit_out_q;
	logic [5:0]       slot_out_q;
	logic [31:0]      value_out_q;

	logic             is_axis;
	logic             valid_kind;
	logic             neg;
	logic [31:0]      num;
	logic [31:0]      den;
	logic [31:0]      quot;
	logic             div_done;
	logic [31:0]      mag;
	logic [KEY_W-1:0] key;
	logic             pressed;
	logic             out_free;
	logic [6:0]       goal;
	logic [CW-1:0]    cnt_inc;
	logic             terminal;
	logic             wr_en;
	logic [1:0]       mode_n;
	logic [CW-1:0]    cnt_n;
	logic [KEY_W-1:0] trig_n;
	logic             added_n;
	logic             hit_n;
	logic [CW-1:0]    slot_n;
	logic [31:0]      sval_n;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THRESHOLD_RESET;
			arm_q <= ARM_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_PRESS_THRESHOLD: thr_q <= cfg_data;
				REG_ARM_REPEAT:      arm_q <= cfg_data[7:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			kind_q <= event_kind;
			code_q <= event_code;
			raw_q  <= raw_value;
			amin_q <= axis_min;
			amax_q <= axis_max;
		end
	end

	// scaling
	assign is_axis    = (kind_q == KIND_AXIS);
	assign valid_kind = (kind_q == KIND_KEY) || is_axis;
	assign neg        = raw_q[31];
	assign num        = neg ? (32'd0 - raw_q) : raw_q;
	assign den        = neg ? (32'd0 - amin_q) : {1'b0, amax_q};

	ibl_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (cmd.div_start),
		.num   (num),
		.den   (den),
		.done  (div_done),
		.quot  (quot)
	);

	always_comb begin
		if (!is_axis)
			mag = 32'd0 - raw_q;
		else if (den == 32'd0)
			mag = 32'd0;
		else
			mag = quot;
	end

	assign key     = {kind_q, code_q, !(is_axis && neg)};
	assign pressed = (mag >= thr_q);

	// table search, one entry per read/compare pair
	always_ff @(posedge clk) begin
		if (wr_en) table_mem[cnt_q[AW-1:0]] <= key;
		if (cmd.srch_rd) rdata_q <= table_mem[idx_q[AW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			found_q     <= 1'b0;
			found_idx_q <= '0;
		end else if (cmd.capture) begin
			idx_q   <= '0;
			found_q <= 1'b0;
		end else if (cmd.srch_cmp) begin
			idx_q <= idx_q + 1'b1;
			if (rdata_q == key) begin
				found_q     <= 1'b1;
				found_idx_q <= idx_q[AW-1:0];
			end
		end
	end

	// mode update
	always_comb begin
		if (arm_q > 8'(PRESS_CNT_MAX))
			goal = PRESS_CNT_MAX;
		else if (arm_q < 8'(ARM_MIN))
			goal = ARM_MIN;
		else
			goal = arm_q[6:0];
	end

	assign cnt_inc  = (cnt_q < CW'(PRESS_CNT_MAX)) ? cnt_q + 1'b1 : cnt_q;
	assign terminal = (key == trig_q);

	always_comb begin
		mode_n  = mode_q;
		cnt_n   = cnt_q;
		trig_n  = trig_q;
		added_n = 1'b0;
		hit_n   = 1'b0;
		slot_n  = '0;
		sval_n  = '0;
		wr_en   = 1'b0;
		if (valid_kind) begin
			if (mode_q != MODE_RUN && pressed) begin
				if (mode_q == MODE_IDLE) begin
					if (terminal) begin
						if (cnt_inc >= CW'(goal)) begin
							mode_n = MODE_LEARN;
							cnt_n  = '0;
						end else begin
							cnt_n = cnt_inc;
						end
					end else begin
						trig_n = key;
						cnt_n  = CW'(1);
					end
				end else if (!(found_q || (cnt_q == '0 && terminal))
						&& cnt_q < CW'(SLOTS)) begin
					wr_en   = cmd.commit;
					slot_n  = cnt_q;
					added_n = 1'b1;
					cnt_n   = cnt_q + 1'b1;
					if (terminal || (cnt_q + 1'b1) >= CW'(SLOTS)) mode_n = MODE_RUN;
				end
			end else if (mode_q == MODE_RUN && found_q) begin
				hit_n  = 1'b1;
				slot_n = CW'(found_idx_q);
				sval_n = mag;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
			cnt_q  <= '0;
			trig_q <= '0;
		end else if (cmd.commit) begin
			mode_q <= mode_n;
			cnt_q  <= cnt_n;
			trig_q <= trig_n;
		end
	end

	// result register
	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			mode_out_q  <= mode_n;
			added_out_q <= added_n;
			hit_out_q   <= hit_n;
			slot_out_q  <= slot_n[5:0];
			value_out_q <= sval_n;
		end
	end

	assign out_valid     = out_valid_q;
	assign mode          = mode_out_q;
	assign binding_added = added_out_q;
	assign slot_hit      = hit_out_q;
	assign slot_index    = slot_out_q;
	assign slot_value    = value_out_q;

	assign status.is_axis     = is_axis;
	assign status.div_done    = div_done;
	assign status.srch_active = valid_kind && (mode_q != MODE_IDLE);
	assign status.srch_more   = (idx_q < cnt_q);
	assign status.found       = found_q;
	assign status.out_free    = out_free;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q != MODE_IDLE) |-> (cnt_q <= CW'(SLOTS)))
		else $error("binding count beyond table size");

	a_commit_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> out_free)
		else $error("commit while result register is held");

	a_cmp_after_rd: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.srch_cmp |-> $past(cmd.srch_rd))
		else $error("compare without a preceding table read");

endmodule

>>> sim/tb_input_binding_learner.sv
// ----------------------------------------------------------------------------
// tb_input_binding_learner: self-checking bench for the input binding learner
// Walks a short table of idle-mode events, most with typed expectations, then
// drives random traffic through idle arming, learning and run mode under
// several threshold and repeat-count settings. Each word is predicted by a
// local model of the learner and compared field by field as it comes out.
// ----------------------------------------------------------------------------
module tb_input_binding_learner;
	import ibl_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int          NSLOTS     = SLOTS_DEFAULT;
	localparam int          QUIET_MAX  = 3000;
	localparam logic [1:0]  KIND_NONE  = 2'd0;
	localparam logic [1:0]  KIND_RSVD  = 2'd3;
	localparam logic [31:0] FULL_SCALE = 32'hFFFF_FFFF;

	typedef struct {
		logic [1:0]  kind;
		logic [9:0]  code;
		logic [31:0] raw;
		logic [31:0] amin;
		logic [30:0] amax;
	} event_word_t;

	typedef struct {
		logic [1:0]  mode;
		logic        added;
		logic        hit;
		logic [5:0]  slot;
		logic [31:0] value;
	} report_t;

	// one directed row: the event plus whether its (idle, all-zero) report
	// is typed in rather than predicted
	typedef struct packed {
		logic [1:0]  kind;
		logic [9:0]  code;
		logic [31:0] raw;
		logic [31:0] amin;
		logic [30:0] amax;
		logic        typed;
	} dir_row_t;

	logic               clk;
	logic               arst_n;
	logic               cfg_we;
	logic               cfg_index;
	logic [31:0]        cfg_data;
	logic               in_valid;
	logic               in_stall;
	logic [1:0]         event_kind;
	logic [9:0]         event_code;
	logic signed [31:0] raw_value;
	logic signed [31:0] axis_min;
	logic [30:0]        axis_max;
	logic               out_valid;
	logic               out_stall;
	logic [1:0]         mode;
	logic               binding_added;
	logic               slot_hit;
	logic [5:0]         slot_index;
	logic [31:0]        slot_value;

	input_binding_learner #(.SLOTS(NSLOTS)) u_dut (.*);

	// model copy of the learner's state and registers
	logic [31:0]        thr_q;
	logic [7:0]         arm_q;
	logic [1:0]         mode_q;
	int                 count_q;
	logic [KEY_W-1:0]   trig_q;
	logic [KEY_W-1:0]   bound_q [NSLOTS];

	report_t pending_reports[$];
	int      errors;
	bit      idling_on;

	// Directed part: every row runs in idle mode under the reset config, so
	// the typed rows all expect an idle report with nothing set.
	dir_row_t dir_rows [13] = '{
		'{KIND_NONE, 10'h3FF, 32'h7FFF_FFFF, 32'h8000_0000, 31'h7FFF_FFFF, 1'b1},
		'{KIND_RSVD, 10'h2AA, 32'hFFFF_FFFF, 32'h0,         31'h1,         1'b1},
		// key at zero: not pressed
		'{KIND_KEY,  10'h000, 32'h0,         32'h0,         31'h0,         1'b1},
		// key at one wraps to full scale: pressed, becomes the trigger
		'{KIND_KEY,  10'h3FF, 32'h1,         32'h0,         31'h0,         1'b1},
		'{KIND_KEY,  10'h3FF, 32'h8000_0000, 32'hFFFF_FFFF, 31'h7FFF_FFFF, 1'b1},
		// key at all ones scales to one: not pressed
		'{KIND_KEY,  10'h155, 32'hFFFF_FFFF, 32'h0,         31'h0,         1'b1},
		// axis with zero extent gives zero
		'{KIND_AXIS, 10'h0F0, 32'h0,         32'h0,         31'h0,         1'b1},
		'{KIND_AXIS, 10'h3FF, 32'h7FFF_FFFF, 32'h0,         31'h7FFF_FFFF, 1'b1},
		'{KIND_AXIS, 10'h3FF, 32'h8000_0000, 32'h8000_0000, 31'h0,         1'b1},
		'{KIND_AXIS, 10'h001, 32'hFFFF_FFFF, 32'h0,         31'h7FFF_FFFF, 1'b1},
		// value beyond the extent: quotient truncated to 32 bits
		'{KIND_AXIS, 10'h2AA, 32'h5,         32'h0,         31'h3,         1'b0},
		'{KIND_AXIS, 10'h155, 32'h7FFF_FFFF, 32'h0,         31'h1,         1'b0},
		'{KIND_AXIS, 10'h0AA, 32'hFFFF_FFF9, 32'hFFFF_FFFE, 31'h5,         1'b0}
	};

	// ---------------------------------------------------------------- model

	function automatic logic [31:0] scale_mag(logic [63:0] m, logic [63:0] ext);
		if (ext == 64'd0)
			return 32'd0;
		return 32'((m * 64'(FULL_SCALE)) / ext);
	endfunction

	function automatic int slot_of(logic [KEY_W-1:0] key);
		for (int i = 0; i < count_q && i < NSLOTS; i++)
			if (bound_q[i] == key)
				return i;
		return -1;
	endfunction

	// advance the model by one event and return its report
	function automatic report_t bind_predict(event_word_t ev);
		report_t          r;
		logic [31:0]      mag;
		logic             pos;
		logic [KEY_W-1:0] key;
		int               goal;
		int               s;
		bit               terminal;
		r = '{default: '0};
		if (ev.kind == KIND_KEY || ev.kind == KIND_AXIS) begin
			if (ev.kind == KIND_KEY) begin
				pos = 1'b1;
				mag = scale_mag({32'd0, ev.raw}, 64'd1);
			end else if (ev.raw[31]) begin
				pos = 1'b0;
				mag = scale_mag({32'd0, 32'(32'd0 - ev.raw)}, {32'd0, 32'(32'd0 - ev.amin)});
			end else begin
				pos = 1'b1;
				mag = scale_mag({32'd0, ev.raw}, {33'd0, ev.amax});
			end
			key = {ev.kind, ev.code, pos};
			if (mode_q != MODE_RUN && mag >= thr_q) begin
				if (mode_q == MODE_IDLE) begin
					if (key == trig_q) begin
						goal = (arm_q > 127) ? 127 : ((arm_q < 2) ? 2 : int'(arm_q));
						if (count_q < 127)
							count_q++;
						if (count_q >= goal) begin
							mode_q = MODE_LEARN;
							count_q = 0;
						end
					end else begin
						trig_q = key;
						count_q = 1;
					end
				end else begin
					terminal = (key == trig_q);
					if (!(slot_of(key) >= 0 || (count_q == 0 && terminal)) &&
					    count_q < NSLOTS) begin
						bound_q[count_q] = key;
						r.slot = 6'(count_q);
						r.added = 1'b1;
						count_q++;
						if (terminal || count_q >= NSLOTS)
							mode_q = MODE_RUN;
					end
				end
			end else if (mode_q == MODE_RUN) begin
				s = slot_of(key);
				if (s >= 0) begin
					r.hit = 1'b1;
					r.slot = 6'(s);
					r.value = mag;
				end
			end
		end
		r.mode = mode_q;
		return r;
	endfunction

	// ------------------------------------------------------------ stimulus

	// random event aimed at one input; pressed words sit near full scale
	function automatic event_word_t aim_event(logic [KEY_W-1:0] key, bit pressed);
		event_word_t ev;
		logic [31:0] a;
		logic [31:0] r;
		ev.kind = key[12:11];
		ev.code = key[10:1];
		ev.amin = {1'b1, 31'($urandom)};
		ev.amax = 31'($urandom);
		ev.raw  = $urandom;
		if (ev.kind == KIND_KEY) begin
			if (pressed)
				ev.raw = $urandom_range(1, 32'h7FFF_FFFF);
		end else if (key[0]) begin
			ev.amax = 31'($urandom_range(1, 32'h7FFF_FFFF));
			r = pressed ? 32'(ev.amax) - $urandom_range(0, 32'(ev.amax) >> 2)
			            : $urandom_range(0, 32'(ev.amax));
			ev.raw = r;
		end else begin
			a = $urandom_range(1, 32'h8000_0000);
			ev.amin = 32'd0 - a;
			r = pressed ? a - $urandom_range(0, a >> 2) : $urandom_range(1, a);
			ev.raw = 32'd0 - r;
		end
		return ev;
	endfunction

	function automatic event_word_t noise_event();
		event_word_t ev;
		ev.kind = 2'($urandom);
		ev.code = 10'($urandom);
		ev.raw  = $urandom;
		ev.amin = ($urandom_range(0, 7) == 0) ? 32'd0 : {1'b1, 31'($urandom)};
		ev.amax = ($urandom_range(0, 7) == 0) ? 31'd0 : 31'($urandom);
		return ev;
	endfunction

	function automatic logic [KEY_W-1:0] any_input();
		logic [1:0] k;
		k = $urandom_range(0, 1) ? KIND_KEY : KIND_AXIS;
		return {k, 10'($urandom), (k == KIND_KEY) ? 1'b1 : 1'($urandom)};
	endfunction

	// hold the word until taken, then book its report
	task automatic send_word(event_word_t ev, bit typed);
		report_t exp_r;
		if (idling_on && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		in_valid   <= 1'b1;
		event_kind <= ev.kind;
		event_code <= ev.code;
		raw_value  <= ev.raw;
		axis_min   <= ev.amin;
		axis_max   <= ev.amax;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		exp_r = bind_predict(ev);
		if (typed)
			exp_r = '{MODE_IDLE, 1'b0, 1'b0, 6'd0, 32'd0};
		pending_reports.push_back(exp_r);
	endtask

	// drop valid and wait until every report is back
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_reports.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// hold the enable high; the caller drops it after its last write
	task automatic write_reg(logic idx, logic [31:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		if (idx == REG_PRESS_THRESHOLD)
			thr_q = val;
		else
			arm_q = val[7:0];
	endtask

	task automatic set_config(logic [31:0] thr, logic [31:0] arm);
		drain();
		write_reg(REG_PRESS_THRESHOLD, thr);
		write_reg(REG_ARM_REPEAT, arm);
		cfg_we <= 1'b0;
	endtask

	// idle traffic: noise mixed with short runs of one input, too short to arm
	task automatic idle_traffic(int n);
		logic [KEY_W-1:0] k;
		int               len;
		while (n > 0) begin
			if ($urandom_range(0, 1)) begin
				send_word(noise_event(), 1'b0);
				n--;
			end else begin
				k = any_input();
				len = $urandom_range(2, 6);
				repeat (len) send_word(aim_event(k, 1'b1), 1'b0);
				n -= len;
			end
		end
	endtask

	// run traffic: mostly bound inputs at any value, some unbound ones
	task automatic run_traffic(int n);
		repeat (n) begin
			if ($urandom_range(0, 9) < 7)
				send_word(aim_event(bound_q[$urandom_range(0, count_q - 1)],
				                    1'($urandom)), 1'b0);
			else if ($urandom_range(0, 1))
				send_word(aim_event(any_input(), 1'($urandom)), 1'b0);
			else
				send_word(noise_event(), 1'b0);
		end
	endtask

	// ---------------------------------------------------------------- clock

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// --------------------------------------------------------------- result

	int stall_left;

	task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] got_v);
		if (exp_v !== got_v) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, got_v);
			errors++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		report_t exp_r;
		if (!arst_n) begin
			out_stall  <= 1'b0;
			stall_left = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (pending_reports.size() == 0) begin
					$display("%0t: report with none expected, actual mode %0h slot %0h",
					         $time, mode, slot_index);
					errors++;
				end else begin
					exp_r = pending_reports.pop_front();
					check_field("mode", exp_r.mode, mode);
					check_field("binding_added", exp_r.added, binding_added);
					check_field("slot_hit", exp_r.hit, slot_hit);
					check_field("slot_index", exp_r.slot, slot_index);
					check_field("slot_value", exp_r.value, slot_value);
				end
			end
			// hold off the output in short bursts
			if (stall_left > 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else if (idling_on && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(0, 2);
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------- watchdog

	int quiet_cycles;

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_MAX) begin
			$display("tb_input_binding_learner failed");
			$finish;
		end
	end

	// ---------------------------------------------------------------- main

	initial begin
		logic [KEY_W-1:0] k;
		arst_n     = 1'b0;
		cfg_we     = 1'b0;
		cfg_index  = REG_PRESS_THRESHOLD;
		cfg_data   = 32'd0;
		in_valid   = 1'b0;
		event_kind = KIND_NONE;
		event_code = 10'd0;
		raw_value  = 32'sd0;
		axis_min   = 32'sd0;
		axis_max   = 31'd0;
		errors       = 0;
		quiet_cycles = 0;
		idling_on    = 1'b1;
		thr_q   = THRESHOLD_RESET;
		arm_q   = ARM_RESET;
		mode_q  = MODE_IDLE;
		count_q = 0;
		trig_q  = '0;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table under the reset config
		foreach (dir_rows[i])
			send_word('{dir_rows[i].kind, dir_rows[i].code, dir_rows[i].raw,
			            dir_rows[i].amin, dir_rows[i].amax}, dir_rows[i].typed);
		// nine identical presses: one short of arming at the reset count
		repeat (9) send_word(aim_event({KIND_KEY, 10'h155, 1'b1}, 1'b1), 1'b0);

		// idle mode under extreme settings; runs never reach the arm goal
		set_config(32'd0, 32'd255);
		idle_traffic(35);
		set_config(FULL_SCALE, 32'd200);
		idle_traffic(35);
		set_config($urandom, 32'h0000_0180);
		idle_traffic(35);
		set_config(THRESHOLD_RESET, 32'd127);
		idle_traffic(35);

		// arm on the second identical press
		set_config(THRESHOLD_RESET, 32'd0);
		k = any_input();
		while (mode_q == MODE_IDLE)
			send_word(aim_event(k, 1'b1), 1'b0);

		// learning: trigger first is ignored, then new inputs, repeats, noise;
		// a random hit on the trigger ends learning early
		send_word(aim_event(trig_q, 1'b1), 1'b0);
		while (count_q < 40 && mode_q == MODE_LEARN) begin
			case ($urandom_range(0, 19)) inside
				[0:11]:  send_word(aim_event(any_input(), 1'b1), 1'b0);
				[12:14]: begin
					if (count_q > 0)
						send_word(aim_event(bound_q[$urandom_range(0, count_q - 1)],
						                    1'b1), 1'b0);
					else
						send_word(noise_event(), 1'b0);
				end
				default: send_word(noise_event(), 1'b0);
			endcase
		end
		while (mode_q != MODE_RUN)
			send_word(aim_event(trig_q, 1'b1), 1'b0);

		// run mode under further settings; the last stretch has no idling
		set_config(32'd0, 32'd1);
		run_traffic(75);
		set_config(FULL_SCALE, 32'd255);
		run_traffic(75);
		set_config($urandom, $urandom);
		idling_on = 1'b0;
		run_traffic(75);

		drain();
		repeat (250) @(posedge clk);
		if (errors == 0)
			$display("tb_input_binding_learner passed");
		else
			$display("tb_input_binding_learner failed");
		$finish;
	end

endmodule
